@@ hw/rtl/ras_pkg.sv @@
// ----------------------------------------------------------------------------
// ras_pkg
// Shared types and constants for the ranked average sorter.
// ----------------------------------------------------------------------------
package ras_pkg;

  localparam int MAX_RECORDS_DEF = 8;
  localparam int NUM_SCORES      = 2;
  localparam int QUEUE_DEPTH     = 4;

  localparam int TAG_W   = 8;
  localparam int SCORE_W = 10;
  localparam int MEAN_W  = 10;
  localparam int RANK_W  = 3;

  localparam int IN_DATA_W  = 32;
  localparam int OUT_DATA_W = 24;

  localparam int QPTR_W = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

  // only the two score fields exist, so the mean is either a halving or a copy
  localparam bit MEAN_HALF = (NUM_SCORES >= 2);

  typedef struct packed {
    logic [TAG_W-1:0]  tag;
    logic [MEAN_W-1:0] mean;
    logic              last;
  } rec_t;

  typedef struct packed {
    logic [RANK_W-1:0] rank;
    logic [TAG_W-1:0]  tag;
    logic [MEAN_W-1:0] mean;
    logic              overflow;
    logic              last;
  } result_t;

  typedef struct packed {
    logic full;
    logic empty;
  } queue_status_t;

  typedef enum logic {
    ST_INSERT,
    ST_DRAIN
  } back_state_t;

endpackage

@@ hw/rtl/ras_front.sv @@
// ----------------------------------------------------------------------------
// ras_front
// Input side: takes a record word, forms the truncated mean, queues it.
// ----------------------------------------------------------------------------
module ras_front (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_tvalid,
  output logic                            s_tready,
  input  logic [ras_pkg::IN_DATA_W-1:0]   s_tdata,
  input  logic                            s_tlast,
  input  ras_pkg::queue_status_t          q_status,
  output logic                            push,
  output ras_pkg::rec_t                   push_rec
);

  logic [ras_pkg::SCORE_W-1:0] score_a;
  logic [ras_pkg::SCORE_W-1:0] score_b;
  logic [ras_pkg::SCORE_W:0]   score_sum;

  assign score_a   = s_tdata[ras_pkg::TAG_W +: ras_pkg::SCORE_W];
  assign score_b   = s_tdata[ras_pkg::TAG_W + ras_pkg::SCORE_W +: ras_pkg::SCORE_W];
  assign score_sum = {1'b0, score_a} + {1'b0, score_b};

  assign s_tready = !q_status.full;
  assign push     = s_tvalid && s_tready;

  always_comb begin
    push_rec.tag  = s_tdata[ras_pkg::TAG_W-1:0];
    push_rec.last = s_tlast;
    if (ras_pkg::MEAN_HALF) begin
      push_rec.mean = score_sum[ras_pkg::SCORE_W:1];
    end else begin
      push_rec.mean = score_a;
    end
  end

endmodule

@@ hw/rtl/ras_queue.sv @@
// ----------------------------------------------------------------------------
// ras_queue
// Short FIFO between the front and the sorting back end.
// ----------------------------------------------------------------------------
module ras_queue (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   push,
  input  ras_pkg::rec_t          push_rec,
  input  logic                   pop,
  output ras_pkg::rec_t          head_rec,
  output ras_pkg::queue_status_t status
);

  ras_pkg::rec_t               slots [ras_pkg::QUEUE_DEPTH];
  logic [ras_pkg::QPTR_W-1:0]  wr_ptr;
  logic [ras_pkg::QPTR_W-1:0]  rd_ptr;
  logic [ras_pkg::QCNT_W-1:0]  fill;

  assign status.full  = (fill == ras_pkg::QCNT_W'(ras_pkg::QUEUE_DEPTH));
  assign status.empty = (fill == '0);
  assign head_rec     = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_rec;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        fill <= fill + 1'b1;
      end else if (pop && !push) begin
        fill <= fill - 1'b1;
      end
    end
  end

endmodule

@@ hw/rtl/ras_back.sv @@
// ----------------------------------------------------------------------------
// ras_back
// Insertion chain kept in descending mean order; drains the ranked run
// through an output register on a record marked last.
// ----------------------------------------------------------------------------
module ras_back #(
  parameter int MAX_RECORDS = ras_pkg::MAX_RECORDS_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  ras_pkg::queue_status_t q_status,
  input  ras_pkg::rec_t          head_rec,
  output logic                   pop,
  output logic                   out_valid,
  input  logic                   out_ready,
  output ras_pkg::result_t       out_res
);

  localparam int CNT_W = $clog2(MAX_RECORDS + 1);

  logic [ras_pkg::TAG_W-1:0]  tags     [MAX_RECORDS];
  logic [ras_pkg::MEAN_W-1:0] means    [MAX_RECORDS];
  logic [ras_pkg::TAG_W-1:0]  up_tag   [MAX_RECORDS];
  logic [ras_pkg::MEAN_W-1:0] up_mean  [MAX_RECORDS];
  logic [ras_pkg::TAG_W-1:0]  dn_tag   [MAX_RECORDS];
  logic [ras_pkg::MEAN_W-1:0] dn_mean  [MAX_RECORDS];
  logic [MAX_RECORDS-1:0]     ge;
  logic [MAX_RECORDS-1:0]     up_ge;

  logic [CNT_W-1:0]           count;
  logic                       dropped;
  logic [ras_pkg::RANK_W-1:0] rank;
  logic                       store_full;
  logic                       do_insert;
  logic                       load_out;

  ras_pkg::back_state_t state, state_next;

  assign store_full = (count == CNT_W'(MAX_RECORDS));
  assign do_insert  = pop && !store_full;

  // a cell holds if its mean is >= the new one; the stored prefix is descending
  always_comb begin
    for (int i = 0; i < MAX_RECORDS; i++) begin
      ge[i] = (CNT_W'(i) < count) && (means[i] >= head_rec.mean);
    end
  end

  genvar g;
  generate
    for (g = 0; g < MAX_RECORDS; g++) begin : g_link
      if (g == 0) begin : g_head
        assign up_tag[g]  = head_rec.tag;
        assign up_mean[g] = head_rec.mean;
        assign up_ge[g]   = 1'b1;
      end else begin : g_mid
        assign up_tag[g]  = tags[g-1];
        assign up_mean[g] = means[g-1];
        assign up_ge[g]   = ge[g-1];
      end
      if (g == MAX_RECORDS - 1) begin : g_tail
        assign dn_tag[g]  = tags[g];
        assign dn_mean[g] = means[g];
      end else begin : g_body
        assign dn_tag[g]  = tags[g+1];
        assign dn_mean[g] = means[g+1];
      end
    end
  endgenerate

  always_ff @(posedge clk) begin
    for (int i = 0; i < MAX_RECORDS; i++) begin
      if (do_insert) begin
        if (!ge[i]) begin
          if (up_ge[i]) begin
            tags[i]  <= head_rec.tag;
            means[i] <= head_rec.mean;
          end else begin
            tags[i]  <= up_tag[i];
            means[i] <= up_mean[i];
          end
        end
      end else if (load_out) begin
        tags[i]  <= dn_tag[i];
        means[i] <= dn_mean[i];
      end
    end
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ras_pkg::ST_INSERT: begin
        if (!q_status.empty && head_rec.last) begin
          state_next = ras_pkg::ST_DRAIN;
        end
      end
      ras_pkg::ST_DRAIN: begin
        if (load_out && count == CNT_W'(1)) begin
          state_next = ras_pkg::ST_INSERT;
        end
      end
      default: state_next = ras_pkg::ST_INSERT;
    endcase
  end

  // outputs
  always_comb begin
    pop      = 1'b0;
    load_out = 1'b0;
    case (state)
      ras_pkg::ST_INSERT: pop      = !q_status.empty;
      ras_pkg::ST_DRAIN:  load_out = !out_valid || out_ready;
      default: begin
        pop      = 1'b0;
        load_out = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ras_pkg::ST_INSERT;
      count   <= '0;
      dropped <= 1'b0;
      rank    <= '0;
    end else begin
      state <= state_next;
      if (do_insert) begin
        count <= count + 1'b1;
      end else if (load_out) begin
        count <= count - 1'b1;
      end
      if (pop && store_full) begin
        dropped <= 1'b1;
      end else if (load_out && count == CNT_W'(1)) begin
        dropped <= 1'b0;
      end
      if (pop) begin
        rank <= '0;
      end else if (load_out) begin
        rank <= rank + 1'b1;
      end
    end
  end

  // output register: cell 0 is always the next rank
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_res.rank     <= rank;
      out_res.tag      <= tags[0];
      out_res.mean     <= means[0];
      out_res.overflow <= dropped;
      out_res.last     <= (count == CNT_W'(1));
    end
  end

endmodule

@@ hw/rtl/ranked_average_sorter.sv @@
// ----------------------------------------------------------------------------
// ranked_average_sorter
// Ranks records by truncated mean score, highest first, stable on ties.
// ----------------------------------------------------------------------------
//  channel | dir | tdata fields (low bit up)              | tlast       | tuser
//  s_      | in  | record_tag, score_first, score_second  | last_record | -
//  m_      | out | rank, ranked_tag, mean_score           | last_out    | overflow
//
//  Front takes one word per cycle while the 4-entry queue has room.
//  The insertion chain places one queued record per cycle; a record marked
//  last is followed by its run of N results, N = stored count, one per
//  cycle while m_tready allows; the queue then fills and holds off s_tready.
//  With an empty queue, the last word of a run passes the queue, the
//  insertion chain and the output register before its first result is valid.
//  rst clears counters, queue and flags; stored records need no clearing.
// ----------------------------------------------------------------------------
module ranked_average_sorter #(
  parameter int MAX_RECORDS = ras_pkg::MAX_RECORDS_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_tvalid,
  output logic                           s_tready,
  // record_tag[7:0], score_first[17:8], score_second[27:18], zero pad
  input  logic [ras_pkg::IN_DATA_W-1:0]  s_tdata,
  input  logic                           s_tlast,
  output logic                           m_tvalid,
  input  logic                           m_tready,
  // rank[2:0], ranked_tag[10:3], mean_score[20:11], zero pad
  output logic [ras_pkg::OUT_DATA_W-1:0] m_tdata,
  // overflow[0]
  output logic                           m_tuser,
  output logic                           m_tlast
);

  logic                   push;
  logic                   pop;
  ras_pkg::rec_t          push_rec;
  ras_pkg::rec_t          head_rec;
  ras_pkg::queue_status_t q_status;
  ras_pkg::result_t       res;

  ras_front u_front (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .q_status (q_status),
    .push     (push),
    .push_rec (push_rec)
  );

  ras_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_rec (push_rec),
    .pop      (pop),
    .head_rec (head_rec),
    .status   (q_status)
  );

  ras_back #(
    .MAX_RECORDS (MAX_RECORDS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .q_status  (q_status),
    .head_rec  (head_rec),
    .pop       (pop),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_res   (res)
  );

  assign m_tdata = {3'b000, res.mean, res.tag, res.rank};
  assign m_tuser = res.overflow;
  assign m_tlast = res.last;

endmodule

@@ verif/testbench.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking regression for ranked_average_sorter. Records go in on the
// s_ stream, a shadow ranking store predicts every ranked word of each batch,
// and each word leaving the m_ stream is checked against the oldest
// prediction. Random gaps on both sides, plus a long output hold-off.
// ----------------------------------------------------------------------------
module testbench;

  localparam int CYCLE_LIMIT = 200000;
  localparam int HOLD_LEN    = 300;

  typedef struct {
    logic [ras_pkg::TAG_W-1:0]   tag;
    logic [ras_pkg::SCORE_W-1:0] first;
    logic [ras_pkg::SCORE_W-1:0] second;
    logic                        last;
  } score_rec_t;

  logic                           clk;
  logic                           rst;
  logic                           s_tvalid;
  logic                           s_tready;
  logic [ras_pkg::IN_DATA_W-1:0]  s_tdata;
  logic                           s_tlast;
  logic                           m_tvalid;
  logic                           m_tready;
  logic [ras_pkg::OUT_DATA_W-1:0] m_tdata;
  logic                           m_tuser;
  logic                           m_tlast;

  // shadow of the ranking store
  logic [ras_pkg::TAG_W-1:0]  shadow_tags  [ras_pkg::MAX_RECORDS_DEF];
  logic [ras_pkg::MEAN_W-1:0] shadow_means [ras_pkg::MAX_RECORDS_DEF];
  int                         shadow_count;
  bit                         shadow_dropped;

  ras_pkg::result_t ranking_q[$];
  ras_pkg::result_t want;
  int      mismatches;
  int      cycle_count;
  int      records_sent;
  bit      tx_idle_on;
  bit      rx_idle_on;
  int      hold_requests;
  int      hold_served;
  int      hold_left;
  int      rx_gap_left;

  ranked_average_sorter dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // mostly short gaps, now and then a long one
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic void rank_record(input score_rec_t r);
    int                         sum;
    int                         pos;
    logic [ras_pkg::MEAN_W-1:0] avg;
    ras_pkg::result_t           w;
    sum = int'(r.first) + ((ras_pkg::NUM_SCORES >= 2) ? int'(r.second) : 0);
    avg = ras_pkg::MEAN_W'(sum / ((ras_pkg::NUM_SCORES >= 2) ? 2 : 1));
    if (shadow_count >= ras_pkg::MAX_RECORDS_DEF) begin
      shadow_dropped = 1'b1;
    end else begin
      // new record goes after every mean >= its own, which keeps ties stable
      pos = shadow_count;
      while (pos > 0 && shadow_means[pos-1] < avg) begin
        shadow_tags[pos]  = shadow_tags[pos-1];
        shadow_means[pos] = shadow_means[pos-1];
        pos--;
      end
      shadow_tags[pos]  = r.tag;
      shadow_means[pos] = avg;
      shadow_count++;
    end
    if (r.last) begin
      for (int k = 0; k < shadow_count; k++) begin
        w.rank     = ras_pkg::RANK_W'(k);
        w.tag      = shadow_tags[k];
        w.mean     = shadow_means[k];
        w.overflow = shadow_dropped;
        w.last     = (k == shadow_count - 1);
        ranking_q.push_back(w);
      end
      shadow_count   = 0;
      shadow_dropped = 1'b0;
    end
  endfunction

  task automatic send_record(input logic [ras_pkg::TAG_W-1:0]   tag,
                             input logic [ras_pkg::SCORE_W-1:0] first,
                             input logic [ras_pkg::SCORE_W-1:0] second,
                             input logic                        last);
    int         gap;
    score_rec_t r;
    r.tag    = tag;
    r.first  = first;
    r.second = second;
    r.last   = last;
    gap = tx_idle_on ? pick_gap() : 0;
    @(negedge clk);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {{(ras_pkg::IN_DATA_W - ras_pkg::TAG_W - 2*ras_pkg::SCORE_W){1'b0}},
                 second, first, tag};
    s_tlast  <= last;
    do @(posedge clk); while (!s_tready);
    rank_record(r);
    records_sent++;
  endtask

  // drop valid and let every pending ranked word come out
  task automatic settle();
    @(negedge clk);
    s_tvalid <= 1'b0;
    while (ranking_q.size() != 0) @(posedge clk);
  endtask

  task automatic report(input string field, input logic [31:0] exp_v,
                        input logic [31:0] got_v);
    $display("mismatch @%0d: %s expected %0h got %0h", cycle_count, field, exp_v, got_v);
    mismatches++;
  endtask

  function automatic logic [ras_pkg::SCORE_W-1:0] rand_score();
    int r;
    r = $urandom_range(0, 19);
    // push ties
    if (r < 4) return ras_pkg::SCORE_W'((r == 0) ? 0 : (r == 1) ? 1000 : 500);
    if (r == 4) return ras_pkg::SCORE_W'($urandom_range(1001, 1023));
    return ras_pkg::SCORE_W'($urandom_range(0, 1000));
  endfunction

  // output side: random gaps, or a long hold-off when a test asks for one
  always @(negedge clk) begin
    if (hold_served != hold_requests) begin
      hold_served = hold_requests;
      hold_left   = HOLD_LEN;
    end
    if (hold_left > 0) begin
      hold_left--;
      m_tready <= 1'b0;
    end else if (!rx_idle_on) begin
      m_tready <= 1'b1;
    end else if (rx_gap_left > 0) begin
      rx_gap_left--;
      m_tready <= 1'b0;
    end else begin
      m_tready <= 1'b1;
      rx_gap_left = pick_gap();
    end
  end

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      if (ranking_q.size() == 0) begin
        report("word with nothing pending, tdata", 32'h0, 32'(m_tdata));
      end else begin
        want = ranking_q.pop_front();
        if (m_tdata[2:0] !== want.rank) report("rank", 32'(want.rank), 32'(m_tdata[2:0]));
        if (m_tdata[10:3] !== want.tag) report("ranked_tag", 32'(want.tag), 32'(m_tdata[10:3]));
        if (m_tdata[20:11] !== want.mean)
          report("mean_score", 32'(want.mean), 32'(m_tdata[20:11]));
        if (m_tuser !== want.overflow) report("overflow", 32'(want.overflow), 32'(m_tuser));
        if (m_tlast !== want.last) report("last_out", 32'(want.last), 32'(m_tlast));
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("ranked_average_sorter regression: fail");
      $finish;
    end
  end

  // one-record batches at the field extremes, truncation and odd bit patterns
  task automatic test_single_records();
    tx_idle_on = 1'b0;
    rx_idle_on = 1'b0;
    send_record(8'h00, 10'd0, 10'd0, 1'b1);
    send_record(8'hff, 10'd1023, 10'd1023, 1'b1);
    send_record(8'haa, 10'd1000, 10'd0, 1'b1);
    send_record(8'h55, 10'd0, 10'd1001, 1'b1);
    send_record(8'h01, 10'd1, 10'd0, 1'b1);
    send_record(8'h5a, 10'h2aa, 10'h155, 1'b1);
    settle();
  endtask

  // full store with equal means: arrival order must hold among ties
  task automatic test_stable_ties();
    tx_idle_on = 1'b1;
    rx_idle_on = 1'b1;
    send_record(8'd20, 10'd500, 10'd500, 1'b0);
    send_record(8'd21, 10'd501, 10'd500, 1'b0);
    send_record(8'd22, 10'd900, 10'd900, 1'b0);
    send_record(8'd23, 10'd0, 10'd0, 1'b0);
    send_record(8'd24, 10'd499, 10'd501, 1'b0);
    send_record(8'd25, 10'd900, 10'd901, 1'b0);
    send_record(8'd26, 10'd1, 10'd0, 1'b0);
    send_record(8'd27, 10'd1023, 10'd1023, 1'b1);
    settle();
  endtask

  // two records more than the store holds, the second dropped one marked last;
  // the next batch must see the flag cleared
  task automatic test_store_full();
    tx_idle_on = 1'b1;
    rx_idle_on = 1'b1;
    for (int i = 0; i < 10; i++)
      send_record(8'(40 + i), rand_score(), rand_score(), i == 9);
    send_record(8'd99, 10'd700, 10'd300, 1'b1);
    settle();
  endtask

  task automatic test_random_batches();
    int start;
    int size;
    start = records_sent;
    while (records_sent - start < 50) begin
      tx_idle_on = ($urandom_range(0, 3) != 0);
      rx_idle_on = ($urandom_range(0, 3) != 0);
      size = ($urandom_range(0, 9) < 8) ? $urandom_range(1, 8) : $urandom_range(9, 12);
      for (int i = 0; i < size; i++)
        send_record(8'($urandom_range(0, 255)), rand_score(), rand_score(), i == size - 1);
    end
    settle();
  endtask

  // output held off for a long stretch while records keep coming: the
  // queue fills and the input must stall without losing anything
  task automatic test_output_hold();
    tx_idle_on = 1'b0;
    rx_idle_on = 1'b0;
    hold_requests++;
    for (int b = 0; b < 3; b++) begin
      for (int i = 0; i < 8; i++)
        send_record(8'($urandom_range(0, 255)), rand_score(), rand_score(), i == 7);
    end
    send_record(8'($urandom_range(0, 255)), rand_score(), rand_score(), 1'b1);
    settle();
  endtask

  initial begin
    rst            = 1'b1;
    s_tvalid       = 1'b0;
    s_tdata        = '0;
    s_tlast        = 1'b0;
    m_tready       = 1'b0;
    shadow_count   = 0;
    shadow_dropped = 1'b0;
    mismatches     = 0;
    cycle_count    = 0;
    records_sent   = 0;
    tx_idle_on     = 1'b0;
    rx_idle_on     = 1'b0;
    hold_requests  = 0;
    hold_served    = 0;
    hold_left      = 0;
    rx_gap_left    = 0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_single_records();
    test_stable_ties();
    test_store_full();
    test_random_batches();
    test_output_hold();

    repeat (20) @(posedge clk);
    if (mismatches == 0 && ranking_q.size() == 0) begin
      $display("ranked_average_sorter regression: pass");
    end else begin
      $display("ranked_average_sorter regression: fail");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
hw/rtl/ras_pkg.sv
hw/rtl/ras_front.sv
hw/rtl/ras_queue.sv
hw/rtl/ras_back.sv
hw/rtl/ranked_average_sorter.sv
verif/testbench.sv
